>>> rtl/assert_macros.svh
// assertion macros shared by the receiver rtl
// no dependencies; clock and active-low reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// expression never holds
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/tsl_pkg.sv
// shared types, code table and symbol classifier for the 2-of-7 link receiver
// no dependencies
package tsl_pkg;

  localparam int SYM_W     = 7;
  localparam int COUNT_W   = 5;
  localparam int NIB_W     = 4;
  localparam int SPEED_W   = 16;
  localparam int CODE_CNT  = 17;
  localparam int POS_W     = 5;

  localparam logic [SYM_W-1:0] EOP_CODE = 7'h60;
  localparam logic [POS_W-1:0] EOP_POS  = 5'd16;

  localparam logic [COUNT_W-1:0] SLOT_N0 = 5'd2;
  localparam logic [COUNT_W-1:0] SLOT_N1 = 5'd3;
  localparam logic [COUNT_W-1:0] SLOT_N2 = 5'd4;
  localparam logic [COUNT_W-1:0] SLOT_N3 = 5'd5;

  localparam logic [SYM_W-1:0] CODE_TABLE [CODE_CNT] = '{
    7'h11, 7'h12, 7'h14, 7'h18, 7'h21, 7'h22, 7'h24, 7'h28,
    7'h41, 7'h42, 7'h44, 7'h48, 7'h03, 7'h06, 7'h0C, 7'h09, 7'h60
  };

  // classified symbol as it travels from front to back
  typedef struct packed {
    logic             eop;
    logic             data_ok;
    logic [NIB_W-1:0] nibble;
  } sym_entry_t;

  // table position of a code, CODE_CNT when absent
  function automatic logic [POS_W-1:0] code_pos(input logic [SYM_W-1:0] code);
    logic [POS_W-1:0] pos;
    pos = POS_W'(CODE_CNT);
    for (int k = CODE_CNT - 1; k >= 0; k--) begin
      if (CODE_TABLE[k] == code) begin
        pos = POS_W'(k);
      end
    end
    return pos;
  endfunction

  function automatic sym_entry_t classify(input logic [SYM_W-1:0] symbol);
    sym_entry_t       e;
    logic [POS_W-1:0] pos;
    pos       = code_pos(symbol);
    e.eop     = (symbol == EOP_CODE);
    e.data_ok = (pos < EOP_POS);
    e.nibble  = pos[NIB_W-1:0];
    return e;
  endfunction

endpackage

>>> rtl/tsl_front.sv
// front end: takes wire levels, recovers the transition symbol and classifies it
// depends on tsl_pkg
module tsl_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tsl_pkg::SYM_W-1:0]  in_wire_levels,
  input  logic                       q_full,
  output logic                       q_push,
  output tsl_pkg::sym_entry_t        q_push_entry
);

  logic [tsl_pkg::SYM_W-1:0] prev_r;
  logic [tsl_pkg::SYM_W-1:0] prev_nxt;
  logic [tsl_pkg::SYM_W-1:0] symbol;

  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full;
  assign symbol       = in_wire_levels ^ prev_r;
  assign q_push_entry = tsl_pkg::classify(symbol);
  assign prev_nxt     = q_push ? in_wire_levels : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

>>> rtl/tsl_queue.sv
// short queue of classified symbols between front and back
// depends on tsl_pkg and assert_macros.svh
`include "assert_macros.svh"

module tsl_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tsl_pkg::sym_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output tsl_pkg::sym_entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsl_pkg::sym_entry_t slots_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  `ASSERT_NEVER(a_no_overfill, clk, rst_n, count_r > CNT_W'(DEPTH))
  `ASSERT_IMPLIES(a_empty_ptrs, clk, rst_n, count_r == '0, rd_ptr_r == wr_ptr_r)
  `ASSERT_NEXT(a_push_lands, clk, rst_n, push && !pop, head_valid)

endmodule

>>> rtl/tsl_back.sv
// back end: packet counting, nibble collection, speed word and result register
// depends on tsl_pkg and assert_macros.svh
`include "assert_macros.svh"

module tsl_back #(
  parameter int MAX_SYMBOLS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  tsl_pkg::sym_entry_t           q_entry,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ack_level,
  output logic                          out_packet_done,
  output logic                          out_speed_updated,
  output logic                          out_symbol_error,
  output logic [tsl_pkg::SPEED_W-1:0]   out_speed_word
);

  localparam logic [tsl_pkg::COUNT_W-1:0] LAST_SLOT =
    tsl_pkg::COUNT_W'(MAX_SYMBOLS - 1);

  logic [tsl_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [tsl_pkg::SPEED_W-1:0] acc_r, acc_nxt, acc_ins;
  logic [tsl_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic                        bad_r, bad_nxt;
  logic                        ack_r, ack_nxt;
  logic                        in_data, bad_now, done, err, upd;

  logic                        out_valid_r;
  logic                        out_done_r, out_upd_r, out_err_r;

  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    in_data = (cnt_r inside {[tsl_pkg::SLOT_N0:tsl_pkg::SLOT_N3]});
    bad_now = in_data && !q_entry.data_ok;
    acc_ins = acc_r;
    if (in_data && q_entry.data_ok) begin
      case (cnt_r)
        tsl_pkg::SLOT_N0: acc_ins[3:0]   = q_entry.nibble;
        tsl_pkg::SLOT_N1: acc_ins[7:4]   = q_entry.nibble;
        tsl_pkg::SLOT_N2: acc_ins[11:8]  = q_entry.nibble;
        tsl_pkg::SLOT_N3: acc_ins[15:12] = q_entry.nibble;
        default:          acc_ins        = acc_r;
      endcase
    end
    done = q_entry.eop || (cnt_r >= LAST_SLOT);
    err  = done && ((cnt_r < tsl_pkg::SLOT_N3) || bad_r || bad_now);
    upd  = done && !err;

    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    bad_nxt   = bad_r;
    ack_nxt   = ack_r;
    speed_nxt = speed_r;
    if (q_pop) begin
      ack_nxt = !ack_r;
      if (done) begin
        cnt_nxt = '0;
        acc_nxt = '0;
        bad_nxt = 1'b0;
        if (upd) begin
          speed_nxt = acc_ins;
        end
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        acc_nxt = acc_ins;
        bad_nxt = bad_r || bad_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      acc_r       <= '0;
      bad_r       <= 1'b0;
      ack_r       <= 1'b0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      bad_r   <= bad_nxt;
      ack_r   <= ack_nxt;
      speed_r <= speed_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each popped request
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_done_r <= done;
      out_upd_r  <= upd;
      out_err_r  <= err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ack_level     = ack_r;
  assign out_packet_done   = out_done_r;
  assign out_speed_updated = out_upd_r;
  assign out_symbol_error  = out_err_r;
  assign out_speed_word    = speed_r;

  `ASSERT_NEVER(a_count_range, clk, rst_n, cnt_r > LAST_SLOT)
  `ASSERT_IMPLIES(a_flags_need_end, clk, rst_n,
    out_valid_r && (out_upd_r || out_err_r), out_done_r && (out_upd_r != out_err_r))
  `ASSERT_NEXT(a_end_clears, clk, rst_n, q_pop && done, cnt_r == '0 && !bad_r)

endmodule

>>> rtl/two_of_seven_link_receiver_top.sv
// Receiver for a seven-wire transition-coded 2-of-7 link. Each request carries the
// wire levels after one symbol event; one result comes back per request with the
// toggled acknowledge level, packet end, speed-update and error flags and the
// current 16-bit speed word. One request per clock is sustained while the output
// does not stall: the front recovers and classifies the symbol in the cycle it is
// taken, a two-entry queue hands it to the back, which updates packet state and
// loads the result register.
// The queue and the result register absorb up to three requests under output stall.
// depends on tsl_pkg, tsl_front, tsl_queue, tsl_back
module two_of_seven_link_receiver_top #(
  parameter int MAX_SYMBOLS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tsl_pkg::SYM_W-1:0]   in_wire_levels,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ack_level,
  output logic                        out_packet_done,
  output logic                        out_speed_updated,
  output logic                        out_symbol_error,
  output logic [tsl_pkg::SPEED_W-1:0] out_speed_word
);

  logic                q_full, q_push, q_pop, q_valid;
  tsl_pkg::sym_entry_t q_push_entry, q_head;

  tsl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_wire_levels (in_wire_levels),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_push_entry   (q_push_entry)
  );

  tsl_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  tsl_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_entry           (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ack_level     (out_ack_level),
    .out_packet_done   (out_packet_done),
    .out_speed_updated (out_speed_updated),
    .out_symbol_error  (out_symbol_error),
    .out_speed_word    (out_speed_word)
  );

endmodule
